// File: hdl/etc_pkg.sv
// Shared types, constants and codes for the elimination tree column count block.
// Used by the channel interfaces, the row memory, the core and the top level.
package etc_pkg;

  localparam int unsigned MAX_SIZE = 64;
  localparam int unsigned IDX_W    = $clog2(MAX_SIZE);
  localparam int unsigned SIZE_W   = $clog2(MAX_SIZE + 1);
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned TOTAL_W  = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_ENTRY  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_READ   = 2'd3
  } etc_cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_BELOW = 2'd1,
    STAT_ORDER = 2'd2,
    STAT_RANGE = 2'd3
  } etc_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_DONE
  } etc_state_e;

  typedef struct packed {
    logic             known;
    logic [IDX_W-1:0] parent;
    logic [IDX_W-1:0] mark;
    logic [IDX_W-1:0] count;
  } etc_row_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
  } etc_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   parent;
    logic               has_parent;
    logic [IDX_W-1:0]   col_count;
    logic [TOTAL_W-1:0] total_count;
  } etc_res_t;

endpackage

// File: hdl/etc_if.sv
// Valid/ready channel interfaces: command items in, result items out, size register write.
// Depends on etc_pkg for field widths.
interface etc_in_if;
  logic                        valid;
  logic                        ready;
  logic [etc_pkg::CMD_W-1:0]   command;
  logic [etc_pkg::IDX_W-1:0]   row_index;
  logic [etc_pkg::IDX_W-1:0]   col_index;
  modport source (output valid, command, row_index, col_index, input ready);
  modport sink   (input valid, command, row_index, col_index, output ready);
endinterface

interface etc_out_if;
  logic                        valid;
  logic                        ready;
  logic [etc_pkg::STAT_W-1:0]  status;
  logic [etc_pkg::IDX_W-1:0]   parent;
  logic                        has_parent;
  logic [etc_pkg::IDX_W-1:0]   col_count;
  logic [etc_pkg::TOTAL_W-1:0] total_count;
  modport source (output valid, status, parent, has_parent, col_count, total_count,
                  input ready);
  modport sink   (input valid, status, parent, has_parent, col_count, total_count,
                  output ready);
endinterface

interface etc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [etc_pkg::SIZE_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/elimination_tree_column_counts.sv
// Top level of the elimination tree and column count block: size register and result register.
// Depends on etc_pkg, etc_if and etc_core.
//
// Usage: after a start item, send pattern entries (row, column) of the upper triangle in
// ascending column order, then a finish item, then read items for each column. Every item
// gives exactly one result item on out_o carrying the sticky status and the running total.
// cfg_i writes matrix_size (0 acts as 1, above 64 acts as 64); write it only while idle.
// Results: out_o.valid is raised by the output register after the core's done state. Start,
// finish and out-of-range reads go straight to that state; in-range reads pass one read
// and one evaluate step; an entry walks the tree and updates k nodes (k < matrix_size).
// With out_o.ready high the next item can be taken in the same cycle as the result appears.
// The walk sets how long an entry takes: each tree step is one read of the row memory and one
// evaluate-and-write step. One item is in work at a time; in_i.ready is low meanwhile.
// A result waits in the output register while out_o.ready is low; the next item is accepted
// once the core is idle and that register is free or being taken.
// Reset clears the status, column position, tables and total, and sets matrix_size to 64.
module elimination_tree_column_counts (
  input  logic      clk_i,
  input  logic      rst_ni,
  etc_in_if.sink    in_i,
  etc_out_if.source out_o,
  etc_cfg_if.sink   cfg_i
);

  localparam int unsigned SW = etc_pkg::SIZE_W;

  logic [SW-1:0]     size_q;
  logic [SW-1:0]     size_eff;
  logic              core_idle;
  logic              core_done;
  logic              go;
  etc_pkg::etc_req_t req;
  etc_pkg::etc_res_t core_res;
  etc_pkg::etc_res_t out_q;
  logic              out_valid_q;

  assign size_eff = (size_q == '0) ? SW'(1) :
                    (size_q > SW'(etc_pkg::MAX_SIZE)) ? SW'(etc_pkg::MAX_SIZE) : size_q;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = core_idle && (!out_valid_q || out_o.ready);
  assign go          = in_i.valid && in_i.ready;

  assign req.command   = in_i.command;
  assign req.row_index = in_i.row_index;
  assign req.col_index = in_i.col_index;

  etc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .req_i  (req),
    .size_i (size_eff),
    .idle_o (core_idle),
    .done_o (core_done),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SW'(etc_pkg::MAX_SIZE);
    end else if (cfg_i.valid && cfg_i.ready) begin
      size_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      out_q <= core_res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.parent      = out_q.parent;
  assign out_o.has_parent  = out_q.has_parent;
  assign out_o.col_count   = out_q.col_count;
  assign out_o.total_count = out_q.total_count;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> !in_i.ready)
    else $error("input taken while an item is still in work");

  a_done_into_free_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> !out_valid_q)
    else $error("result overwrites an item not yet taken");

  a_parent_above_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.has_parent |-> out_q.parent != '0)
    else $error("tree parent of column zero or missing");

endmodule

// File: hdl/etc_row_ram.sv
// Single-port-write, single-port-read row memory holding parent, visit mark and count per node.
// Depends on etc_pkg for the row type and depth.
module etc_row_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [etc_pkg::IDX_W-1:0] waddr_i,
  input  etc_pkg::etc_row_t         wdata_i,
  input  logic [etc_pkg::IDX_W-1:0] raddr_i,
  output etc_pkg::etc_row_t         rdata_o
);

  etc_pkg::etc_row_t mem [etc_pkg::MAX_SIZE];
  etc_pkg::etc_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/etc_core.sv
// Command sequencer and tree walker: one row memory read per walk step, plus a write for each node it updates.
// Depends on etc_pkg and etc_row_ram.
module etc_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  etc_pkg::etc_req_t         req_i,
  input  logic [etc_pkg::SIZE_W-1:0] size_i,
  output logic                      idle_o,
  output logic                      done_o,
  output etc_pkg::etc_res_t         res_o
);

  localparam int unsigned IW = etc_pkg::IDX_W;
  localparam int unsigned SW = etc_pkg::SIZE_W;
  localparam int unsigned MS = etc_pkg::MAX_SIZE;

  etc_pkg::etc_state_e  state_q, state_d;
  etc_pkg::etc_status_e err_q, err_d;
  etc_pkg::etc_cmd_e    cmd_q, cmd_d;
  logic [IW-1:0]        node_q, node_d;
  logic [IW-1:0]        col_q, col_d;
  logic [IW-1:0]        cur_q, cur_d;
  logic                 cur_valid_q, cur_valid_d;
  logic [MS-1:0]        row_valid_q, row_valid_d;
  logic [etc_pkg::TOTAL_W-1:0] total_q, total_d;
  logic                 range_q, range_d;
  logic [IW-1:0]        par_q, par_d;
  logic                 hasp_q, hasp_d;
  logic [IW-1:0]        cnt_q, cnt_d;

  logic                 we;
  logic [IW-1:0]        waddr;
  etc_pkg::etc_row_t    wdata;
  etc_pkg::etc_row_t    rdata;
  etc_pkg::etc_row_t    row_cur;
  etc_pkg::etc_cmd_e    cmd_in;
  logic [SW-1:0]        row_w, col_w, cur_next;

  etc_row_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (node_q),
    .rdata_o (rdata)
  );

  assign cmd_in   = etc_pkg::etc_cmd_e'(req_i.command);
  assign row_w    = {1'b0, req_i.row_index};
  assign col_w    = {1'b0, req_i.col_index};
  assign cur_next = {1'b0, cur_q} + SW'(1);
  assign row_cur  = row_valid_q[node_q] ? rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= etc_pkg::ST_IDLE;
      err_q       <= etc_pkg::STAT_OK;
      cmd_q       <= etc_pkg::CMD_START;
      node_q      <= '0;
      col_q       <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      row_valid_q <= '0;
      total_q     <= '0;
      range_q     <= 1'b0;
      par_q       <= '0;
      hasp_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      cmd_q       <= cmd_d;
      node_q      <= node_d;
      col_q       <= col_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      row_valid_q <= row_valid_d;
      total_q     <= total_d;
      range_q     <= range_d;
      par_q       <= par_d;
      hasp_q      <= hasp_d;
      cnt_q       <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    cmd_d       = cmd_q;
    node_d      = node_q;
    col_d       = col_q;
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    row_valid_d = row_valid_q;
    total_d     = total_q;
    range_d     = range_q;
    par_d       = par_q;
    hasp_d      = hasp_q;
    cnt_d       = cnt_q;
    we          = 1'b0;
    waddr       = req_i.col_index;
    wdata       = '0;
    done_o      = 1'b0;

    case (state_q)
      etc_pkg::ST_IDLE: begin
        if (go_i) begin
          cmd_d   = cmd_in;
          col_d   = req_i.col_index;
          node_d  = req_i.row_index;
          range_d = 1'b0;
          par_d   = '0;
          hasp_d  = 1'b0;
          cnt_d   = '0;
          state_d = etc_pkg::ST_DONE;
          case (cmd_in)
            etc_pkg::CMD_START: begin
              err_d       = etc_pkg::STAT_OK;
              cur_d       = '0;
              cur_valid_d = 1'b0;
              row_valid_d = '0;
              total_d     = '0;
            end
            etc_pkg::CMD_ENTRY: begin
              if (err_q == etc_pkg::STAT_OK) begin
                if (row_w >= size_i || col_w >= size_i) begin
                  err_d = etc_pkg::STAT_RANGE;
                end else if (req_i.row_index > req_i.col_index) begin
                  err_d = etc_pkg::STAT_BELOW;
                end else if (!cur_valid_q && req_i.col_index != '0) begin
                  err_d = etc_pkg::STAT_ORDER;
                end else if (cur_valid_q && req_i.col_index != cur_q
                             && col_w != cur_next) begin
                  err_d = etc_pkg::STAT_ORDER;
                end else begin
                  if (!cur_valid_q || req_i.col_index != cur_q) begin
                    we          = 1'b1;
                    wdata.mark  = req_i.col_index;
                    row_valid_d[req_i.col_index] = 1'b1;
                    cur_d       = req_i.col_index;
                    cur_valid_d = 1'b1;
                  end
                  state_d = etc_pkg::ST_RD;
                end
              end
            end
            etc_pkg::CMD_FINISH: begin
              if (err_q == etc_pkg::STAT_OK && (!cur_valid_q || cur_next != size_i)) begin
                err_d = etc_pkg::STAT_ORDER;
              end
            end
            etc_pkg::CMD_READ: begin
              if (col_w >= size_i) begin
                range_d = 1'b1;
              end else begin
                node_d  = req_i.col_index;
                state_d = etc_pkg::ST_RD;
              end
            end
            default: begin
              state_d = etc_pkg::ST_DONE;
            end
          endcase
        end
      end
      etc_pkg::ST_RD: begin
        state_d = etc_pkg::ST_EV;
      end
      etc_pkg::ST_EV: begin
        if (cmd_q == etc_pkg::CMD_READ) begin
          hasp_d  = row_cur.known;
          par_d   = row_cur.known ? row_cur.parent : '0;
          cnt_d   = row_cur.count;
          state_d = etc_pkg::ST_DONE;
        end else if (row_cur.mark == col_q) begin
          state_d = etc_pkg::ST_DONE;
        end else begin
          we           = 1'b1;
          waddr        = node_q;
          wdata.known  = 1'b1;
          wdata.parent = row_cur.known ? row_cur.parent : col_q;
          wdata.mark   = col_q;
          wdata.count  = row_cur.count + IW'(1);
          row_valid_d[node_q] = 1'b1;
          total_d = total_q + etc_pkg::TOTAL_W'(1);
          node_d  = wdata.parent;
          state_d = etc_pkg::ST_RD;
        end
      end
      etc_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = etc_pkg::ST_IDLE;
      end
      default: begin
        state_d = etc_pkg::ST_IDLE;
      end
    endcase
  end

  assign idle_o            = (state_q == etc_pkg::ST_IDLE);
  assign res_o.status      = (range_q && err_q == etc_pkg::STAT_OK) ? etc_pkg::STAT_RANGE : err_q;
  assign res_o.parent      = par_q;
  assign res_o.has_parent  = hasp_q;
  assign res_o.col_count   = cnt_q;
  assign res_o.total_count = total_q;

endmodule
